// ===== sv/ctp_pkg.sv =====
package ctp_pkg;

  localparam int DUR_W      = 32;
  localparam int TAG_PORT_W = 16;
  localparam int SLOT_OUT_W = 3;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_POLL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_DONE   = 2'd2
  } status_t;

  // The tag is kept last so that the stored copy can drop its unused upper bits.
  typedef struct packed {
    status_t                 status;
    logic                    periodic;
    logic                    handler_valid;
    logic [DUR_W-1:0]        duration;
    logic [DUR_W-1:0]        remaining;
    logic [TAG_PORT_W-1:0]   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/ctp_ram.sv =====
module ctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ctp_slot_eval.sv =====
module ctp_slot_eval (
  input  ctp_pkg::entry_t cur,
  input  logic            is_tick,
  output ctp_pkg::entry_t upd,
  output logic            fire
);

  always_comb begin
    upd  = cur;
    fire = 1'b0;
    if (is_tick) begin
      if (cur.status == ctp_pkg::ST_ACTIVE && cur.remaining != '0) begin
        upd.remaining = cur.remaining - ctp_pkg::DUR_W'(1);
        if (cur.remaining == ctp_pkg::DUR_W'(1)) begin
          upd.status = ctp_pkg::ST_DONE;
        end
      end
    end else if (cur.status == ctp_pkg::ST_DONE && cur.handler_valid) begin
      fire = 1'b1;
      if (cur.periodic) begin
        upd.remaining = cur.duration;
        upd.status    = ctp_pkg::ST_ACTIVE;
      end else begin
        upd.status        = ctp_pkg::ST_IDLE;
        upd.handler_valid = 1'b0;
      end
    end
  end

endmodule

// ===== sv/countdown_timer_pool.sv =====
// Channel   Handshake             Ports
// input     start & !busy         in_mode, in_duration_ms, in_periodic, in_has_handler,
//                                 in_handler_tag
// result    out_valid, one cycle  out_kind, out_accepted, out_slot, out_fired_tag, out_last
//
// A start is handled while idle and its reply appears in the next cycle.
// A tick or a poll walks the claimed slots newest first, one per cycle, and keeps busy high
// until the walk is done; with no slot claimed it stays idle, and only a poll replies (empty).
// Fired results leave in the cycle after the next is found; the last one leaves as busy falls.
// Reset is synchronous; the slot memory needs no clearing because only claimed slots are read.
// The receiver cannot stall results.
module countdown_timer_pool #(
  parameter int SLOT_COUNT = 8,
  parameter int TAG_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_duration_ms,
  input  logic        in_periodic,
  input  logic        in_has_handler,
  input  logic [15:0] in_handler_tag,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic        out_accepted,
  output logic [2:0]  out_slot,
  output logic [15:0] out_fired_tag,
  output logic        out_last
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int TW = (TAG_BITS < ctp_pkg::TAG_PORT_W) ? TAG_BITS : ctp_pkg::TAG_PORT_W;
  localparam int TPW = ctp_pkg::TAG_PORT_W;
  localparam int EW = ctp_pkg::ENTRY_W;
  localparam int RW = EW - TPW + TW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic              tick_r, tick_nxt;
  logic              iss_r, iss_nxt;
  logic [SW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              pv_r, pv_nxt;
  logic [SW-1:0]     pv_idx_r, pv_idx_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [SW-1:0]     pend_slot_r, pend_slot_nxt;
  logic [TPW-1:0]    pend_tag_r, pend_tag_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic              out_accepted_r, out_accepted_nxt;
  logic [2:0]        out_slot_r, out_slot_nxt;
  logic [TPW-1:0]    out_tag_r, out_tag_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata;
  logic [RW-1:0]     ram_rdata;
  ctp_pkg::entry_t   wr_ent;
  ctp_pkg::entry_t   rd_ent;
  ctp_pkg::entry_t   upd_ent;
  logic              fire;

  assign ram_wdata = {wr_ent[EW-1:TPW], wr_ent.tag[TW-1:0]};
  assign rd_ent    = {ram_rdata[RW-1:TW], TPW'(ram_rdata[TW-1:0])};

  ctp_ram #(
    .WIDTH(RW),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  ctp_slot_eval u_eval (
    .cur    (rd_ent),
    .is_tick(tick_r),
    .upd    (upd_ent),
    .fire   (fire)
  );

  always_comb begin
    state_nxt        = state_r;
    used_nxt         = used_r;
    tick_nxt         = tick_r;
    iss_nxt          = iss_r;
    rd_idx_nxt       = rd_idx_r;
    pv_nxt           = pv_r;
    pv_idx_nxt       = pv_idx_r;
    pend_v_nxt       = pend_v_r;
    pend_slot_nxt    = pend_slot_r;
    pend_tag_nxt     = pend_tag_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_accepted_nxt = out_accepted_r;
    out_slot_nxt     = out_slot_r;
    out_tag_nxt      = out_tag_r;
    out_last_nxt     = out_last_r;
    ram_we           = 1'b0;
    ram_waddr        = pv_idx_r;
    wr_ent           = upd_ent;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_mode) inside
            ctp_pkg::MODE_START: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = ctp_pkg::KIND_REPLY;
              out_tag_nxt   = '0;
              out_last_nxt  = 1'b1;
              if (used_r == CW'(SLOT_COUNT)) begin
                out_accepted_nxt = 1'b0;
                out_slot_nxt     = '0;
              end else begin
                ram_we               = 1'b1;
                ram_waddr            = used_r[SW-1:0];
                wr_ent.status        = ctp_pkg::ST_ACTIVE;
                wr_ent.periodic      = in_periodic;
                wr_ent.handler_valid = in_has_handler;
                wr_ent.duration      = in_duration_ms;
                wr_ent.remaining     = in_duration_ms;
                wr_ent.tag           = TPW'(in_handler_tag[TW-1:0]);
                out_accepted_nxt     = 1'b1;
                out_slot_nxt         = 3'(used_r);
                used_nxt             = used_r + CW'(1);
              end
            end
            ctp_pkg::MODE_TICK, ctp_pkg::MODE_POLL: begin
              if (used_r == '0) begin
                if (in_mode == ctp_pkg::MODE_POLL) begin
                  out_valid_nxt    = 1'b1;
                  out_kind_nxt     = ctp_pkg::KIND_EMPTY;
                  out_accepted_nxt = 1'b0;
                  out_slot_nxt     = '0;
                  out_tag_nxt      = '0;
                  out_last_nxt     = 1'b1;
                end
              end else begin
                state_nxt  = S_WALK;
                tick_nxt   = (in_mode == ctp_pkg::MODE_TICK);
                iss_nxt    = 1'b1;
                rd_idx_nxt = SW'(used_r - CW'(1));
                pend_v_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        pv_nxt     = iss_r;
        pv_idx_nxt = rd_idx_r;
        if (iss_r) begin
          if (rd_idx_r == '0) begin
            iss_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - SW'(1);
          end
        end
        if (pv_r) begin
          ram_we = 1'b1;
          if (fire) begin
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = pv_idx_r;
            pend_tag_nxt  = rd_ent.tag;
            if (pend_v_r) begin
              out_valid_nxt    = 1'b1;
              out_kind_nxt     = ctp_pkg::KIND_FIRED;
              out_accepted_nxt = 1'b0;
              out_slot_nxt     = 3'(pend_slot_r);
              out_tag_nxt      = pend_tag_r;
              out_last_nxt     = 1'b0;
            end
          end
        end
        if (!iss_r && !pv_r) begin
          state_nxt = S_IDLE;
          if (!tick_r) begin
            out_valid_nxt    = 1'b1;
            out_accepted_nxt = 1'b0;
            out_last_nxt     = 1'b1;
            if (pend_v_r) begin
              out_kind_nxt = ctp_pkg::KIND_FIRED;
              out_slot_nxt = 3'(pend_slot_r);
              out_tag_nxt  = pend_tag_r;
            end else begin
              out_kind_nxt = ctp_pkg::KIND_EMPTY;
              out_slot_nxt = '0;
              out_tag_nxt  = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      iss_r       <= 1'b0;
      pv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r         <= tick_nxt;
    rd_idx_r       <= rd_idx_nxt;
    pv_idx_r       <= pv_idx_nxt;
    pend_slot_r    <= pend_slot_nxt;
    pend_tag_r     <= pend_tag_nxt;
    out_kind_r     <= out_kind_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_slot_r     <= out_slot_nxt;
    out_tag_r      <= out_tag_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_accepted  = out_accepted_r;
  assign out_slot      = out_slot_r;
  assign out_fired_tag = out_tag_r;
  assign out_last      = out_last_r;

endmodule
